// ===== hdl/mqtt_receive_deframer_core_assert.svh =====
// ----------------------------------------------------------------------------
// MQTT receive deframer assertion macros
// Concurrent assertion wrappers, compiled away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef MQTT_RECEIVE_DEFRAMER_CORE_ASSERT_SVH
`define MQTT_RECEIVE_DEFRAMER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// The consequent must hold in the same cycle as the antecedent.
`define MRD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// The expression must never be true outside reset.
`define MRD_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);
`else
`define MRD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define MRD_ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

// ===== hdl/mrd_pkg.sv =====
// ----------------------------------------------------------------------------
// MQTT receive deframer package
// Parser phases, result codes and the entry passed from front to back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mrd_pkg;

  typedef enum logic [2:0] {
    PH_HDR   = 3'd0,
    PH_LEN   = 3'd1,
    PH_TLHI  = 3'd2,
    PH_TLLO  = 3'd3,
    PH_TOPIC = 3'd4,
    PH_PID   = 3'd5,
    PH_PAY   = 3'd6,
    PH_SKIP  = 3'd7
  } phase_t;

  localparam logic [1:0] KIND_TOPIC   = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_DONE    = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_TOPIC_LEN = 2'd1;
  localparam logic [1:0] ERR_MALFORMED = 2'd2;
  localparam logic [1:0] ERR_SHORT     = 2'd3;

  localparam logic [3:0] PKT_PUBLISH = 4'd3;

  // Topics of this many bytes or more are rejected.
  localparam logic [16:0] TOPIC_MAX = 17'd64;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  // One accepted byte yields at most a data beat followed by a closing beat.
  typedef struct packed {
    logic       first_valid;
    logic       first_payload;
    logic [7:0] data;
    logic       second_valid;
    logic       second_error;
    logic [1:0] error_code;
    logic [1:0] qos;
    logic [5:0] topic_length;
    logic [7:0] payload_length;
  } entry_t;

endpackage

`default_nettype wire

// ===== hdl/mrd_byte_if.sv =====
// ----------------------------------------------------------------------------
// Received byte channel
// Valid/ready channel carrying one byte of the MQTT stream per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mrd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== hdl/mrd_result_if.sv =====
// ----------------------------------------------------------------------------
// Deframer result channel
// Valid/ready channel carrying one topic, payload, completion or error beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mrd_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data;
  logic [1:0] qos_level;
  logic [5:0] topic_length;
  logic [7:0] payload_length;
  logic [1:0] error_code;
  logic       last;

  modport source (output valid, output kind, output data, output qos_level,
                  output topic_length, output payload_length,
                  output error_code, output last, input ready);
  modport sink   (input valid, input kind, input data, input qos_level,
                  input topic_length, input payload_length,
                  input error_code, input last, output ready);
endinterface

`default_nettype wire

// ===== hdl/mrd_front.sv =====
// ----------------------------------------------------------------------------
// MQTT receive deframer front end
// Byte-serial packet parser; turns each byte into at most one queue entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mrd_front #(
  parameter int PAYLOAD_MAX = 256
) (
  input  logic            clk,
  input  logic            rst,
  mrd_byte_if.sink        rx,
  output mrd_pkg::entry_t entry,
  output logic            push,
  input  logic            full
);
  import mrd_pkg::*;

  localparam int PeW = $clog2(PAYLOAD_MAX);

  phase_t         phase, phase_next;
  logic [3:0]     packet_type, packet_type_next;
  logic [1:0]     qos_held, qos_held_next;
  logic [27:0]    length_accumulator, length_accumulator_next;
  logic [2:0]     length_byte_count, length_byte_count_next;
  logic [27:0]    bytes_left, bytes_left_next;
  logic [15:0]    topic_size, topic_size_next;
  logic [15:0]    field_counter, field_counter_next;
  logic [PeW-1:0] payload_emitted, payload_emitted_next;

  logic           fire;
  logic [7:0]     b;
  logic [27:0]    len_shifted;
  logic [27:0]    acc_new;
  logic [2:0]     cnt_new;
  logic           len_bad;
  logic [27:0]    bl_dec;
  logic           at_end;
  logic           qos_any;
  logic [15:0]    ts_new;
  logic [16:0]    need;
  logic           too_long;
  logic           short_pub;
  logic [15:0]    fc_inc;
  logic           topic_done;
  logic           pid_done;
  logic           can_emit;
  logic [PeW-1:0] pe_new;
  logic [PeW-1:0] pe_fin;
  logic [PeW+7:0] pe_ext;

  assign rx.ready = !full;
  assign fire     = rx.valid && rx.ready;
  assign b        = rx.rx_byte;

  always_comb begin
    case (length_byte_count[1:0])
      2'd0: len_shifted = {21'd0, b[6:0]};
      2'd1: len_shifted = {14'd0, b[6:0], 7'd0};
      2'd2: len_shifted = {7'd0, b[6:0], 14'd0};
      2'd3: len_shifted = {b[6:0], 21'd0};
    endcase
  end

  assign acc_new    = length_accumulator | len_shifted;
  assign cnt_new    = length_byte_count + 3'd1;
  assign len_bad    = b[7] && (cnt_new >= 3'd4);
  assign bl_dec     = bytes_left - 28'd1;
  assign at_end     = (bl_dec == 28'd0);
  assign qos_any    = (qos_held != 2'd0);
  assign ts_new     = {topic_size[15:8], b};
  assign need       = {1'b0, ts_new} + (qos_any ? 17'd2 : 17'd0);
  assign too_long   = ({1'b0, ts_new} >= TOPIC_MAX);
  assign short_pub  = ({11'd0, need} > bl_dec);
  assign fc_inc     = field_counter + 16'd1;
  assign topic_done = (fc_inc >= topic_size);
  assign pid_done   = (fc_inc >= 16'd2);
  assign can_emit   = (payload_emitted < PeW'(PAYLOAD_MAX - 1));
  assign pe_new     = payload_emitted + PeW'(1);
  assign pe_fin     = (phase == PH_PAY && can_emit) ? pe_new : payload_emitted;
  assign pe_ext     = (PeW + 8)'(pe_fin);

  // Next state and parser registers.
  always_comb begin
    phase_next              = phase;
    packet_type_next        = packet_type;
    qos_held_next           = qos_held;
    length_accumulator_next = length_accumulator;
    length_byte_count_next  = length_byte_count;
    bytes_left_next         = bytes_left;
    topic_size_next         = topic_size;
    field_counter_next      = field_counter;
    payload_emitted_next    = payload_emitted;
    unique case (phase)
      PH_HDR: begin
        packet_type_next        = b[7:4];
        qos_held_next           = b[2:1];
        length_accumulator_next = '0;
        length_byte_count_next  = '0;
        topic_size_next         = '0;
        field_counter_next      = '0;
        payload_emitted_next    = '0;
        phase_next              = PH_LEN;
      end
      PH_LEN: begin
        length_accumulator_next = acc_new;
        length_byte_count_next  = cnt_new;
        if (b[7]) begin
          if (len_bad) begin
            bytes_left_next = '0;
            phase_next      = PH_HDR;
          end
        end else begin
          bytes_left_next = acc_new;
          if (packet_type == PKT_PUBLISH && acc_new >= 28'd2) begin
            phase_next = PH_TLHI;
          end else begin
            phase_next = (acc_new == 28'd0) ? PH_HDR : PH_SKIP;
          end
        end
      end
      PH_TLHI: begin
        topic_size_next = {b, 8'd0};
        bytes_left_next = bl_dec;
        phase_next      = PH_TLLO;
      end
      PH_TLLO: begin
        topic_size_next = ts_new;
        bytes_left_next = bl_dec;
        if (too_long || short_pub) begin
          phase_next = at_end ? PH_HDR : PH_SKIP;
        end else begin
          field_counter_next = '0;
          if (ts_new != 16'd0) begin
            phase_next = PH_TOPIC;
          end else if (qos_any) begin
            phase_next = PH_PID;
          end else begin
            phase_next = at_end ? PH_HDR : PH_PAY;
          end
        end
      end
      PH_TOPIC: begin
        field_counter_next = fc_inc;
        bytes_left_next    = bl_dec;
        if (topic_done) begin
          field_counter_next = '0;
          if (qos_any) begin
            phase_next = PH_PID;
          end else begin
            phase_next = at_end ? PH_HDR : PH_PAY;
          end
        end
      end
      PH_PID: begin
        field_counter_next = fc_inc;
        bytes_left_next    = bl_dec;
        if (pid_done) begin
          phase_next = at_end ? PH_HDR : PH_PAY;
        end
      end
      PH_PAY: begin
        if (can_emit) begin
          payload_emitted_next = pe_new;
        end
        bytes_left_next = bl_dec;
        if (at_end) begin
          phase_next = PH_HDR;
        end
      end
      PH_SKIP: begin
        if (bytes_left != 28'd0) begin
          bytes_left_next = bl_dec;
        end
        if (bytes_left <= 28'd1) begin
          phase_next = PH_HDR;
        end
      end
      default: phase_next = PH_HDR;
    endcase
  end

  // Queue entry for the byte now being taken.
  always_comb begin
    entry                = '0;
    entry.qos            = qos_held;
    entry.data           = b;
    entry.topic_length   = topic_size[5:0];
    entry.payload_length = pe_ext[7:0];
    unique case (phase)
      PH_LEN: begin
        if (len_bad) begin
          entry.second_valid = 1'b1;
          entry.second_error = 1'b1;
          entry.error_code   = ERR_MALFORMED;
        end else if (!b[7] && packet_type == PKT_PUBLISH && acc_new < 28'd2) begin
          entry.second_valid = 1'b1;
          entry.second_error = 1'b1;
          entry.error_code   = ERR_SHORT;
        end
      end
      PH_TLLO: begin
        if (too_long) begin
          entry.second_valid = 1'b1;
          entry.second_error = 1'b1;
          entry.error_code   = ERR_TOPIC_LEN;
        end else if (short_pub) begin
          entry.second_valid = 1'b1;
          entry.second_error = 1'b1;
          entry.error_code   = ERR_SHORT;
        end else if (ts_new == 16'd0 && !qos_any && at_end) begin
          entry.second_valid = 1'b1;
        end
      end
      PH_TOPIC: begin
        entry.first_valid  = 1'b1;
        entry.second_valid = topic_done && !qos_any && at_end;
      end
      PH_PID: begin
        entry.second_valid = pid_done && at_end;
      end
      PH_PAY: begin
        entry.first_valid   = can_emit;
        entry.first_payload = 1'b1;
        entry.second_valid  = at_end;
      end
      PH_HDR, PH_TLHI, PH_SKIP: begin
        entry.second_valid = 1'b0;
      end
      default: entry.second_valid = 1'b0;
    endcase
    // Error beats carry no counts.
    if (entry.second_error) begin
      entry.topic_length   = '0;
      entry.payload_length = '0;
    end
  end

  assign push = fire && (entry.first_valid || entry.second_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_HDR;
      packet_type        <= '0;
      qos_held           <= '0;
      length_accumulator <= '0;
      length_byte_count  <= '0;
      bytes_left         <= '0;
      topic_size         <= '0;
      field_counter      <= '0;
      payload_emitted    <= '0;
    end else if (fire) begin
      phase              <= phase_next;
      packet_type        <= packet_type_next;
      qos_held           <= qos_held_next;
      length_accumulator <= length_accumulator_next;
      length_byte_count  <= length_byte_count_next;
      bytes_left         <= bytes_left_next;
      topic_size         <= topic_size_next;
      field_counter      <= field_counter_next;
      payload_emitted    <= payload_emitted_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mrd_queue.sv =====
// ----------------------------------------------------------------------------
// MQTT receive deframer entry queue
// Short first-in first-out buffer between the parser and the result stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mrd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mrd_pkg::entry_t wr_entry,
  output logic            full,
  input  logic            pop,
  output mrd_pkg::entry_t head,
  output logic            empty
);
  import mrd_pkg::*;

  entry_t              slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full  = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        count <= count + (QUEUE_AW + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (QUEUE_AW + 1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mrd_back.sv =====
// ----------------------------------------------------------------------------
// MQTT receive deframer result stage
// Holds one queue entry and presents its one or two beats on the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mrd_back (
  input  logic            clk,
  input  logic            rst,
  input  mrd_pkg::entry_t head,
  input  logic            empty,
  output logic            pop,
  mrd_result_if.source    res
);
  import mrd_pkg::*;

  entry_t cur;
  logic   cur_valid;
  logic   on_second;
  logic   take;
  logic   cur_done;

  assign take     = res.valid && res.ready;
  assign cur_done = take && (on_second || !cur.second_valid);
  assign pop      = !empty && (!cur_valid || cur_done);

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      on_second <= 1'b0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      on_second <= !head.first_valid;
    end else if (cur_done) begin
      cur_valid <= 1'b0;
    end else if (take) begin
      on_second <= 1'b1;
    end
  end

  always_comb begin
    res.valid     = cur_valid;
    res.qos_level = cur.qos;
    if (on_second) begin
      res.kind           = cur.second_error ? KIND_ERROR : KIND_DONE;
      res.data           = '0;
      res.topic_length   = cur.topic_length;
      res.payload_length = cur.payload_length;
      res.error_code     = cur.error_code;
      res.last           = 1'b1;
    end else begin
      res.kind           = cur.first_payload ? KIND_PAYLOAD : KIND_TOPIC;
      res.data           = cur.data;
      res.topic_length   = '0;
      res.payload_length = '0;
      res.error_code     = ERR_NONE;
      res.last           = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mqtt_receive_deframer_core.sv =====
// ----------------------------------------------------------------------------
// MQTT receive deframer
// Byte-serial MQTT 3.1.1 receive parser that streams out PUBLISH topic and
// payload bytes, followed by a completion or error beat per packet.
// ----------------------------------------------------------------------------
// Usage
//   rx carries the received byte stream, one byte per beat. res carries the
//   results: topic bytes, payload bytes (truncated to PAYLOAD_MAX-1 per
//   message), then a completion beat with QoS, topic length and payload
//   length, or an error beat with its code. last marks the closing beat.
//   Packets other than PUBLISH are consumed without any result, unless their
//   remaining length is malformed, which gives an error beat. Throughput is
//   one byte per cycle while the queue has room; the parser state updates
//   once per byte, so nothing else in the front end limits the rate.
//   A byte that ends a packet on a topic byte, or on a payload byte that is
//   not truncated, gives two beats, delivered by the result stage in order.
//   Each beat passes through the four-entry queue, then the result register.
//   When the receiver stalls, the queue fills and rx.ready drops once it
//   holds four entries; bytes that produce no result still need a free slot.
//   Synchronous reset returns the parser to waiting for a fixed header and
//   empties the queue and the result register; pending beats are dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "mqtt_receive_deframer_core_assert.svh"

module mqtt_receive_deframer_core #(
  parameter int PAYLOAD_MAX = 256
) (
  input  logic         clk,
  input  logic         rst,
  mrd_byte_if.sink     rx,
  mrd_result_if.source res
);
  import mrd_pkg::*;

  entry_t wr_entry;
  entry_t head;
  logic   push;
  logic   full;
  logic   pop;
  logic   empty;

  // Front: parses the stream and classifies each byte.
  mrd_front #(
    .PAYLOAD_MAX(PAYLOAD_MAX)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx),
    .entry (wr_entry),
    .push  (push),
    .full  (full)
  );

  // Queue: decouples parsing from result delivery.
  mrd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  // Back: registered output, one beat per cycle while res.ready is high.
  mrd_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .res   (res)
  );

  // The front end only pushes into a queue with room.
  `MRD_ASSERT_NEVER(a_no_overflow, clk, rst, push && full, "entry pushed into full queue")
  // The result stage only loads from a non-empty queue.
  `MRD_ASSERT_NEVER(a_no_underflow, clk, rst, pop && empty, "entry popped from empty queue")
  // Closing beats, and only those, carry last.
  `MRD_ASSERT_IMP(a_last_kind, clk, rst, res.valid, res.last == (res.kind == KIND_DONE || res.kind == KIND_ERROR), "last does not match kind")
  // An error beat always names its cause.
  `MRD_ASSERT_IMP(a_err_code, clk, rst, res.valid && res.kind == KIND_ERROR, res.error_code != ERR_NONE, "error beat without code")

endmodule

`default_nettype wire
